@@ hdl/spectrum_to_xyz_rgb_defines.svh @@
// ---------------------------------------------------------------------------
// Spectrum to XYZ/RGB assertion macros
// Concurrent assertion wrappers used by the block's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef SPECTRUM_TO_XYZ_RGB_DEFINES_SVH
`define SPECTRUM_TO_XYZ_RGB_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define STXR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define STXR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STXR_ASSERT(lbl, prop, msg)
`define STXR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ hdl/stxr_pkg.sv @@
// ---------------------------------------------------------------------------
// Spectrum to XYZ/RGB package
// Widths, colour-matching tables, matrix coefficients and control codes.
// ---------------------------------------------------------------------------
package stxr_pkg;

  localparam int TABLE_LENGTH = 60;
  localparam int SAMPLE_BITS  = 16;
  localparam int ROM_SIZE     = 60;
  localparam int ROM_ADDR_W   = $clog2(ROM_SIZE);
  localparam int IDX_W        = 7;
  localparam int ACC_W        = 48;
  localparam int OUT_W        = 32;
  localparam int BW_W         = 16;
  localparam logic [BW_W-1:0] BIN_WIDTH_RESET = 16'd1280;
  localparam logic [1:0] LAST_CHAN = 2'd2;

  // CIE 1931 matching functions in unsigned Q2.14.
  localparam logic [15:0] CMF_X [ROM_SIZE] = '{
    16'd234, 16'd713, 16'd2202, 16'd4651, 16'd5707, 16'd5508, 16'd4764, 16'd3201,
    16'd1566, 16'd524, 16'd80, 16'd152, 16'd1037, 16'd2712, 16'd4758, 16'd7101,
    16'd9740, 16'd12486, 16'd15013, 16'd16815, 16'd17403, 16'd16427, 16'd13998,
    16'd10525, 16'd7338, 16'd4645, 16'd2702, 16'd1432, 16'd767, 16'd372,
    16'd187, 16'd95, 16'd48, 16'd23, 16'd11, 16'd5, 16'd3, 16'd2, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  localparam logic [15:0] CMF_Y [ROM_SIZE] = '{
    16'd7, 16'd20, 16'd66, 16'd190, 16'd377, 16'd623, 16'd983, 16'd1491,
    16'd2277, 16'd3408, 16'd5292, 16'd8241, 16'd11633, 16'd14123, 16'd15630,
    16'd16302, 16'd16302, 16'd15598, 16'd14254, 16'd12403, 16'd10338, 16'd8241,
    16'd6242, 16'd4342, 16'd2867, 16'd1753, 16'd999, 16'd524, 16'd279, 16'd134,
    16'd67, 16'd34, 16'd16, 16'd8, 16'd3, 16'd2, 16'd2, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  localparam logic [15:0] CMF_Z [ROM_SIZE] = '{
    16'd1112, 16'd3398, 16'd10578, 16'd22702, 16'd28624, 16'd29034, 16'd27348,
    16'd21096, 16'd13320, 16'd7622, 16'd4456, 16'd2592, 16'd1281, 16'd691,
    16'd333, 16'd143, 16'd64, 16'd34, 16'd28, 16'd18, 16'd13, 16'd5, 16'd3,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_SCALE_ST,
    ST_MAT_MAC,
    ST_MAT_ST,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCALE_LO,
    OP_SCALE_HI,
    OP_SCALE_ST,
    OP_MAT_MAC,
    OP_MAT_ST
  } op_t;

  typedef struct packed {
    logic       acc_en;
    op_t        op;
    logic [1:0] chan;
    logic [1:0] term;
    logic       emit;
  } cmd_t;

  function automatic logic [15:0] cmf_lookup(input logic [1:0] tab,
                                             input logic [IDX_W-1:0] idx);
    logic [15:0] r;
    r = 16'd0;
    if (idx < IDX_W'(ROM_SIZE)) begin
      case (tab)
        2'd0:    r = CMF_X[idx[ROM_ADDR_W-1:0]];
        2'd1:    r = CMF_Y[idx[ROM_ADDR_W-1:0]];
        default: r = CMF_Z[idx[ROM_ADDR_W-1:0]];
      endcase
    end
    return r;
  endfunction

  // XYZ to linear sRGB (D65) in Q2.14, one row per output channel.
  function automatic logic signed [16:0] srgb_coef(input logic [1:0] row,
                                                   input logic [1:0] col);
    logic signed [16:0] r;
    case ({row, col})
      4'h0:    r = 17'sd53092;
      4'h1:    r = -17'sd25184;
      4'h2:    r = -17'sd8168;
      4'h4:    r = -17'sd15880;
      4'h5:    r = 17'sd30737;
      4'h6:    r = 17'sd681;
      4'h8:    r = 17'sd912;
      4'h9:    r = -17'sd3343;
      4'hA:    r = 17'sd17322;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/stxr_ctrl.sv @@
// ---------------------------------------------------------------------------
// Spectrum to XYZ/RGB controller
// Sequences sample accumulation, scaling, matrix and result hand-off.
// ---------------------------------------------------------------------------
module stxr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output stxr_pkg::cmd_t  cmd
);

  stxr_pkg::state_t state_r, state_nxt;
  logic [1:0] chan_r, chan_nxt;
  logic [1:0] term_r, term_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ok;

  // The output register is free when empty or when its transaction completes now.
  assign emit_ok = (state_r == stxr_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      stxr_pkg::ST_ACC: begin
        if (in_valid && in_last) begin
          state_nxt = stxr_pkg::ST_SCALE_LO;
          chan_nxt  = 2'd0;
        end
      end
      stxr_pkg::ST_SCALE_LO: begin
        state_nxt = stxr_pkg::ST_SCALE_HI;
      end
      stxr_pkg::ST_SCALE_HI: begin
        state_nxt = stxr_pkg::ST_SCALE_ST;
      end
      stxr_pkg::ST_SCALE_ST: begin
        if (chan_r == stxr_pkg::LAST_CHAN) begin
          state_nxt = stxr_pkg::ST_MAT_MAC;
          chan_nxt  = 2'd0;
          term_nxt  = 2'd0;
        end else begin
          state_nxt = stxr_pkg::ST_SCALE_LO;
          chan_nxt  = chan_r + 2'd1;
        end
      end
      stxr_pkg::ST_MAT_MAC: begin
        if (term_r == stxr_pkg::LAST_CHAN) begin
          state_nxt = stxr_pkg::ST_MAT_ST;
        end else begin
          term_nxt = term_r + 2'd1;
        end
      end
      stxr_pkg::ST_MAT_ST: begin
        term_nxt = 2'd0;
        if (chan_r == stxr_pkg::LAST_CHAN) begin
          state_nxt = stxr_pkg::ST_EMIT;
        end else begin
          state_nxt = stxr_pkg::ST_MAT_MAC;
          chan_nxt  = chan_r + 2'd1;
        end
      end
      stxr_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_nxt     = stxr_pkg::ST_ACC;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = stxr_pkg::ST_ACC;
      end
    endcase
  end

  always_comb begin
    in_stall   = (state_r != stxr_pkg::ST_ACC);
    out_valid  = out_valid_r;
    cmd.acc_en = (state_r == stxr_pkg::ST_ACC) && in_valid;
    cmd.chan   = chan_r;
    cmd.term   = term_r;
    cmd.emit   = emit_ok;
    case (state_r)
      stxr_pkg::ST_SCALE_LO: cmd.op = stxr_pkg::OP_SCALE_LO;
      stxr_pkg::ST_SCALE_HI: cmd.op = stxr_pkg::OP_SCALE_HI;
      stxr_pkg::ST_SCALE_ST: cmd.op = stxr_pkg::OP_SCALE_ST;
      stxr_pkg::ST_MAT_MAC:  cmd.op = stxr_pkg::OP_MAT_MAC;
      stxr_pkg::ST_MAT_ST:   cmd.op = stxr_pkg::OP_MAT_ST;
      default:               cmd.op = stxr_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stxr_pkg::ST_ACC;
      chan_r      <= 2'd0;
      term_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/stxr_dp.sv @@
// ---------------------------------------------------------------------------
// Spectrum to XYZ/RGB datapath
// Three sample accumulators, one shared multiply-add unit and result registers.
// ---------------------------------------------------------------------------
module stxr_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stxr_pkg::cmd_t                       cmd,
  input  logic signed [stxr_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                 cfg_we,
  input  logic [stxr_pkg::BW_W-1:0]            cfg_bin_width,
  output logic signed [stxr_pkg::OUT_W-1:0]    out_x_out,
  output logic signed [stxr_pkg::OUT_W-1:0]    out_y_out,
  output logic signed [stxr_pkg::OUT_W-1:0]    out_z_out,
  output logic signed [stxr_pkg::OUT_W-1:0]    out_red,
  output logic signed [stxr_pkg::OUT_W-1:0]    out_green,
  output logic signed [stxr_pkg::OUT_W-1:0]    out_blue,
  output logic                                 out_too_many
);

  localparam int PROD_W = stxr_pkg::SAMPLE_BITS + 17;
  localparam int MUL_W  = 50;

  function automatic logic signed [stxr_pkg::ACC_W-1:0] sat_add(
      input logic signed [stxr_pkg::ACC_W-1:0] a,
      input logic signed [PROD_W-1:0]          p);
    logic signed [stxr_pkg::ACC_W:0] s;
    logic signed [stxr_pkg::ACC_W-1:0] r;
    s = {a[stxr_pkg::ACC_W-1], a} + (stxr_pkg::ACC_W+1)'(p);
    if (s[stxr_pkg::ACC_W] != s[stxr_pkg::ACC_W-1]) begin
      r = s[stxr_pkg::ACC_W] ? {1'b1, {(stxr_pkg::ACC_W-1){1'b0}}}
                             : {1'b0, {(stxr_pkg::ACC_W-1){1'b1}}};
    end else begin
      r = s[stxr_pkg::ACC_W-1:0];
    end
    return r;
  endfunction

  // Round half up, shift right by k, then clamp to the output width.
  function automatic logic signed [stxr_pkg::OUT_W-1:0] rnd_sat(
      input logic signed [63:0] v,
      input logic [5:0]         k);
    logic signed [63:0] h;
    logic signed [63:0] sh;
    logic signed [stxr_pkg::OUT_W-1:0] r;
    h  = v + (64'sd1 <<< (k - 6'd1));
    sh = h >>> k;
    if ((&sh[63:stxr_pkg::OUT_W-1]) || !(|sh[63:stxr_pkg::OUT_W-1])) begin
      r = sh[stxr_pkg::OUT_W-1:0];
    end else begin
      r = sh[63] ? {1'b1, {(stxr_pkg::OUT_W-1){1'b0}}}
                 : {1'b0, {(stxr_pkg::OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  logic [stxr_pkg::BW_W-1:0]             bw_r;
  logic [stxr_pkg::IDX_W-1:0]            idx_r;
  logic                                  excess_r;
  logic signed [stxr_pkg::ACC_W-1:0]     sum_r [3];
  logic signed [63:0]                    acc_r, acc_nxt;
  logic signed [stxr_pkg::OUT_W-1:0]     xyz_r [3];
  logic signed [stxr_pkg::OUT_W-1:0]     rgb_r [3];
  logic signed [PROD_W-1:0]              prod [3];
  logic signed [32:0]                    mul_a;
  logic signed [16:0]                    mul_b;
  logic signed [MUL_W-1:0]               mul_p;
  logic signed [63:0]                    mul_p64;
  logic signed [63:0]                    addend;
  logic signed [63:0]                    base;
  logic signed [stxr_pkg::ACC_W-1:0]     sum_sel;
  logic                                  in_table;

  assign in_table = (idx_r < stxr_pkg::IDX_W'(stxr_pkg::TABLE_LENGTH));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_W'(in_sample) *
                PROD_W'($signed({1'b0, stxr_pkg::cmf_lookup(2'(c), idx_r)}));
    end
  end

  // Shared multiplier: the 48-bit sums are scaled in a low and a high part.
  always_comb begin
    sum_sel = sum_r[cmd.chan];
    mul_a   = 33'sd0;
    mul_b   = $signed({1'b0, bw_r});
    base    = acc_r;
    case (cmd.op)
      stxr_pkg::OP_SCALE_LO: begin
        mul_a = $signed({17'd0, sum_sel[15:0]});
        base  = 64'sd0;
      end
      stxr_pkg::OP_SCALE_HI: begin
        mul_a = 33'($signed(sum_sel[stxr_pkg::ACC_W-1:16]));
      end
      stxr_pkg::OP_MAT_MAC: begin
        mul_a = 33'(xyz_r[cmd.term]);
        mul_b = stxr_pkg::srgb_coef(cmd.chan, cmd.term);
        if (cmd.term == 2'd0) begin
          base = 64'sd0;
        end
      end
      default: begin
        mul_a = 33'sd0;
      end
    endcase
    mul_p   = MUL_W'(mul_a) * MUL_W'(mul_b);
    mul_p64 = 64'(mul_p);
    addend  = (cmd.op == stxr_pkg::OP_SCALE_HI) ? (mul_p64 <<< 16) : mul_p64;
    acc_nxt = base + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r     <= stxr_pkg::BIN_WIDTH_RESET;
      idx_r    <= '0;
      excess_r <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        bw_r <= cfg_bin_width;
      end
      if (cmd.acc_en) begin
        if (in_table) begin
          for (int c = 0; c < 3; c++) begin
            sum_r[c] <= sat_add(sum_r[c], prod[c]);
          end
        end else begin
          excess_r <= 1'b1;
        end
        if (idx_r != {stxr_pkg::IDX_W{1'b1}}) begin
          idx_r <= idx_r + stxr_pkg::IDX_W'(1);
        end
      end
      if (cmd.emit) begin
        idx_r    <= '0;
        excess_r <= 1'b0;
        for (int c = 0; c < 3; c++) begin
          sum_r[c] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == stxr_pkg::OP_SCALE_LO) || (cmd.op == stxr_pkg::OP_SCALE_HI) ||
        (cmd.op == stxr_pkg::OP_MAT_MAC)) begin
      acc_r <= acc_nxt;
    end
    if (cmd.op == stxr_pkg::OP_SCALE_ST) begin
      xyz_r[cmd.chan] <= rnd_sat(acc_r, 6'd22);
    end
    if (cmd.op == stxr_pkg::OP_MAT_ST) begin
      rgb_r[cmd.chan] <= rnd_sat(acc_r, 6'd14);
    end
    if (cmd.emit) begin
      out_x_out    <= xyz_r[0];
      out_y_out    <= xyz_r[1];
      out_z_out    <= xyz_r[2];
      out_red      <= rgb_r[0];
      out_green    <= rgb_r[1];
      out_blue     <= rgb_r[2];
      out_too_many <= excess_r;
    end
  end

endmodule

@@ hdl/spectrum_to_xyz_rgb.sv @@
// ---------------------------------------------------------------------------
// Spectrum to XYZ/RGB
// Integrates a sampled spectrum against the CIE 1931 tables and converts
// the result to linear sRGB.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_stall   in_sample, in_last
//  out      out_valid / out_stall x, y, z, red, green, blue, too_many
//  cfg      cfg_valid / cfg_ready cfg_bin_width
//
// Samples are taken one per cycle while the block is accumulating.
// After the sample marked last, the shared multiply-add unit scales X, Y, Z
// (low, high, store), then each matrix row (multiply-add per term, store), before
// the result is loaded into the output register; in_stall is high throughout.
// The next spectrum may be accumulated while a result waits in the output
// register; its own finish then waits until that result has been taken.
// Reset is synchronous; it sets the bin width to 5 nm and clears the sums.
// ---------------------------------------------------------------------------
`include "spectrum_to_xyz_rgb_defines.svh"

module spectrum_to_xyz_rgb (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [stxr_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                    in_last,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [stxr_pkg::OUT_W-1:0]       out_x_out,
  output logic signed [stxr_pkg::OUT_W-1:0]       out_y_out,
  output logic signed [stxr_pkg::OUT_W-1:0]       out_z_out,
  output logic signed [stxr_pkg::OUT_W-1:0]       out_red,
  output logic signed [stxr_pkg::OUT_W-1:0]       out_green,
  output logic signed [stxr_pkg::OUT_W-1:0]       out_blue,
  output logic                                    out_too_many,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [stxr_pkg::BW_W-1:0]               cfg_bin_width
);

  stxr_pkg::cmd_t cmd;

  // The register is a plain flop, so a write is always taken.
  assign cfg_ready = 1'b1;

  stxr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  stxr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_sample     (in_sample),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_bin_width (cfg_bin_width),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out),
    .out_z_out     (out_z_out),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_too_many  (out_too_many)
  );

  `STXR_ASSERT(a_acc_only_when_open, cmd.acc_en |-> !in_stall, "sample taken while stalled")
  `STXR_ASSERT(a_last_starts_finish, in_valid && !in_stall && in_last |=> in_stall, "no finish after last")
  `STXR_ASSERT(a_emit_sets_valid, cmd.emit |=> out_valid, "result load did not raise out_valid")
  `STXR_ASSERT_RST(a_reset_clears_valid, !rst_n |=> !out_valid, "out_valid set after reset")

endmodule
